>>> hw/rtl/hse_pkg.sv
// shared types, constants and arithmetic helpers for the spline evaluator
package hse_pkg;

   localparam int MaxSegments = 64;
   localparam int FracBits    = 16;
   localparam int WordsPerSeg = 15;
   localparam int SegBits     = $clog2(MaxSegments);
   localparam int TableDepth  = MaxSegments * WordsPerSeg;
   localparam int AddrBits    = $clog2(TableDepth);

   localparam logic [3:0] SelT0  = 4'd0;
   localparam logic [3:0] SelT1  = 4'd1;
   localparam logic [3:0] SelInv = 4'd2;
   localparam logic [3:0] SelP0  = 4'd3;
   localparam logic [3:0] SelP1  = 4'd6;
   localparam logic [3:0] SelM0  = 4'd9;
   localparam logic [3:0] SelM1  = 4'd12;
   localparam logic [3:0] SelLimit = 4'd15;

   typedef logic signed [31:0] word_type;

   typedef struct packed {
      logic            req_type;
      logic [5:0]      entry_index;
      logic [3:0]      word_select;
      logic [31:0]     write_value;
      logic [31:0]     eval_x;
   } req_payload_type;

   typedef struct packed {
      logic [5:0]      segment_used;
      logic [31:0]     pos_x;
      logic [31:0]     pos_y;
      logic [31:0]     pos_z;
      logic [31:0]     tan_x;
      logic [31:0]     tan_y;
      logic [31:0]     tan_z;
      logic [31:0]     curv_x;
      logic [31:0]     curv_y;
      logic [31:0]     curv_z;
   } rsp_payload_type;

   // controller to datapath
   typedef enum logic [3:0] {
      OP_NONE,
      OP_WRITE,
      OP_LOAD_X,
      OP_CMP_FIRST,
      OP_CMP_LAST,
      OP_CMP_PROBE,
      OP_CAP_T0,
      OP_CAP_INV,
      OP_MUL_T,
      OP_MUL_T2,
      OP_MUL_T3,
      OP_WEIGHTS,
      OP_AXIS
   } dp_op_type;

   typedef struct packed {
      dp_op_type            op;
      logic [AddrBits-1:0]  rd_addr;
      logic [SegBits-1:0]   seg;
      logic [1:0]           axis;
      logic [1:0]           term;
      logic                 last_term;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic x_lt_t0;
      logic x_gt_t1;
   } dp_status_type;

   function automatic logic [AddrBits-1:0] table_addr(logic [SegBits-1:0] seg,
                                                      logic [3:0] sel);
      logic [AddrBits+3:0] a;
      a = AddrBits'(seg) * (AddrBits+4)'(WordsPerSeg) + (AddrBits+4)'(sel);
      return a[AddrBits-1:0];
   endfunction

   function automatic logic signed [31:0] sat32(logic signed [67:0] v);
      if (v > 68'sd2147483647) return 32'sh7fffffff;
      if (v < -68'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

endpackage

>>> hw/rtl/hse_stream_if.sv
// valid/ready channel carrying a payload
interface hse_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> hw/rtl/hse_ram.sv
// generic ram with one write port and one registered read port
module hse_ram #(
   parameter int Width = 32,
   parameter int Depth = 960
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

>>> hw/rtl/hse_datapath.sv
// table memory, shared multiplier and accumulators
module hse_datapath (
   input  logic                    clock,
   input  hse_pkg::dp_cmd_type     cmd,
   input  hse_pkg::req_payload_type req,
   output hse_pkg::dp_status_type  status,
   output logic [31:0]             result [9]
);
   import hse_pkg::*;

   logic [31:0] rd_data;
   logic        wr_en;
   word_type    mem_word;

   assign wr_en = (cmd.op == OP_WRITE) && (req.word_select != SelLimit);
   assign mem_word = word_type'(rd_data);

   hse_ram #(.Width(32), .Depth(TableDepth)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(table_addr(req.entry_index[SegBits-1:0], req.word_select)),
      .wr_data(req.write_value),
      .rd_addr(cmd.rd_addr),
      .rd_data(rd_data)
   );

   word_type x_ff, x_in;
   logic signed [32:0] dx_ff, dx_in;
   word_type t_ff, t_in, t2_ff, t2_in, t3_ff, t3_in;
   word_type w_ff [12];
   word_type w_in [12];
   logic signed [33:0] acc_ff [3];
   logic signed [33:0] acc_in [3];
   logic [31:0] res_ff [9];
   logic [31:0] res_in [9];
   dp_status_type status_ff, status_in;

   // shared multiplier operands
   logic signed [32:0] mul_a;
   logic signed [31:0] mul_b;
   logic signed [64:0] prod;
   word_type           prod_sat;

   always_comb begin
      mul_a = 33'(t_ff);
      mul_b = t_ff;
      case (cmd.op)
         OP_MUL_T:  begin mul_a = dx_ff;       mul_b = mem_word; end
         OP_MUL_T2: begin mul_a = 33'(t_ff);   mul_b = t_ff;     end
         OP_MUL_T3: begin mul_a = 33'(t2_ff);  mul_b = t_ff;     end
         default:   begin mul_a = 33'(t_ff);   mul_b = t_ff;     end
      endcase
      prod = mul_a * mul_b;
      prod_sat = sat32(68'(prod >>> FracBits));
   end

   // three weight products for one table word, one per weight family
   logic signed [63:0] wprod [3];
   logic signed [33:0] wterm [3];
   logic [1:0]         wi;
   always_comb begin
      wi = cmd.term;
      for (int k = 0; k < 3; k++) begin
         wprod[k] = w_ff[k*4 + int'(wi)] * mem_word;
         wterm[k] = 34'(sat32(68'(wprod[k] >>> FracBits)));
      end
   end

   logic signed [67:0] a, b, c, one;
   always_comb begin
      x_in = x_ff;
      dx_in = dx_ff;
      t_in = t_ff;
      t2_in = t2_ff;
      t3_in = t3_ff;
      w_in = w_ff;
      acc_in = acc_ff;
      res_in = res_ff;
      status_in = status_ff;
      one = 68'sd1 <<< FracBits;
      a = 68'(t_ff);
      b = 68'(t2_ff);
      c = 68'(t3_ff);
      case (cmd.op)
         OP_LOAD_X: x_in = word_type'(req.eval_x);
         OP_CMP_FIRST: status_in.x_lt_t0 = x_ff < mem_word;
         OP_CMP_LAST:  status_in.x_gt_t1 = x_ff > mem_word;
         OP_CMP_PROBE: begin
            if (cmd.term == 2'd0) status_in.x_lt_t0 = x_ff < mem_word;
            else status_in.x_gt_t1 = x_ff > mem_word;
         end
         OP_CAP_T0: dx_in = 33'(x_ff) - 33'(mem_word);
         OP_MUL_T:  t_in = prod_sat;
         OP_MUL_T2: t2_in = prod_sat;
         OP_MUL_T3: t3_in = prod_sat;
         OP_WEIGHTS: begin
            w_in[0]  = sat32(2*c - 3*b + one);
            w_in[1]  = sat32(c - 2*b + a);
            w_in[2]  = sat32(-2*c + 3*b);
            w_in[3]  = sat32(c - b);
            w_in[4]  = sat32(6*b - 6*a);
            w_in[5]  = sat32(3*b - 4*a + one);
            w_in[6]  = sat32(-6*b + 6*a);
            w_in[7]  = sat32(3*b - 2*a);
            w_in[8]  = sat32(12*a - 6*one);
            w_in[9]  = sat32(6*a - 4*one);
            w_in[10] = sat32(-12*a + 6*one);
            w_in[11] = sat32(6*a - 2*one);
         end
         OP_AXIS: begin
            for (int k = 0; k < 3; k++) begin
               if (cmd.term == 2'd0) acc_in[k] = wterm[k];
               else acc_in[k] = acc_ff[k] + wterm[k];
               if (cmd.last_term) begin
                  res_in[k*3 + int'(cmd.axis)] = sat32(68'(acc_ff[k] + wterm[k]));
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      dx_ff <= dx_in;
      t_ff <= t_in;
      t2_ff <= t2_in;
      t3_ff <= t3_in;
      w_ff <= w_in;
      acc_ff <= acc_in;
      res_ff <= res_in;
      status_ff <= status_in;
   end

   assign status = status_ff;
   assign result = res_ff;
endmodule

>>> hw/rtl/hse_controller.sv
// sequencer: segment search, local t and basis accumulation
module hse_controller (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [6:0]               csr_num_segments,
   input  logic                     req_fire,
   input  logic                     req_is_eval,
   output logic                     req_ready,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output logic [5:0]               seg_out,
   output hse_pkg::dp_cmd_type      cmd,
   input  hse_pkg::dp_status_type   status
);
   import hse_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_FIRST, ST_LAST, ST_CHK_FIRST, ST_CHK_LAST,
      ST_PROBE0, ST_PROBE1, ST_PROBE_WAIT, ST_PROBE_DEC,
      ST_T0, ST_INV, ST_MUL, ST_AXIS, ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic [SegBits:0]   lo_ff, lo_in, hi_ff, hi_in;
   logic [SegBits-1:0] seg_ff, seg_in, last_ff, last_in;
   logic [1:0]         axis_ff, axis_in, term_ff, term_in;
   logic [1:0]         mstep_ff, mstep_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [6:0]         n_clamped;
   logic [SegBits:0]   mid;
   logic [SegBits+1:0] lohi;
   logic [3:0]         term_sel;

   always_comb begin
      if (csr_num_segments == 7'd0) n_clamped = 7'd1;
      else if (csr_num_segments > 7'(MaxSegments)) n_clamped = 7'(MaxSegments);
      else n_clamped = csr_num_segments;
      lohi = (SegBits+2)'(lo_ff) + (SegBits+2)'(hi_ff);
      mid = lohi[SegBits+1:1];
      case (term_ff)
         2'd0:    term_sel = SelP0;
         2'd1:    term_sel = SelM0;
         2'd2:    term_sel = SelP1;
         default: term_sel = SelM1;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      lo_in = lo_ff; hi_in = hi_ff; seg_in = seg_ff; last_in = last_ff;
      axis_in = axis_ff; term_in = term_ff; mstep_in = mstep_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd = '0;
      cmd.op = OP_NONE;
      cmd.seg = seg_ff;
      req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_is_eval) begin
                  cmd.op = OP_LOAD_X;
                  last_in = SegBits'(n_clamped - 7'd1);
                  cmd.rd_addr = table_addr('0, SelT0);
                  state_in = ST_FIRST;
               end else begin
                  cmd.op = OP_WRITE;
               end
            end
         end
         ST_FIRST: begin
            // data for t0 of segment 0 arrives now
            cmd.op = OP_CMP_FIRST;
            cmd.rd_addr = table_addr(last_ff, SelT1);
            state_in = ST_LAST;
         end
         ST_LAST: begin
            cmd.op = OP_CMP_LAST;
            state_in = ST_CHK_FIRST;
         end
         ST_CHK_FIRST: begin
            if (status.x_lt_t0) begin
               seg_in = '0; state_in = ST_T0;
            end else begin
               state_in = ST_CHK_LAST;
            end
         end
         ST_CHK_LAST: begin
            if (status.x_gt_t1) begin
               seg_in = last_ff; state_in = ST_T0;
            end else begin
               lo_in = '0;
               hi_in = (SegBits+1)'(last_ff);
               state_in = ST_PROBE0;
            end
         end
         ST_PROBE0: begin
            seg_in = mid[SegBits-1:0];
            cmd.rd_addr = table_addr(mid[SegBits-1:0], SelT0);
            state_in = ST_PROBE1;
         end
         ST_PROBE1: begin
            cmd.op = OP_CMP_PROBE; cmd.term = 2'd0;
            cmd.rd_addr = table_addr(seg_ff, SelT1);
            state_in = ST_PROBE_WAIT;
         end
         ST_PROBE_WAIT: begin
            cmd.op = OP_CMP_PROBE; cmd.term = 2'd1;
            state_in = ST_PROBE_DEC;
         end
         ST_PROBE_DEC: begin
            if (!status.x_lt_t0 && !status.x_gt_t1) begin
               state_in = ST_T0;
            end else begin
               if (status.x_lt_t0) begin
                  // t0 > x
                  if (seg_ff == '0) state_in = ST_T0;
                  else begin
                     hi_in = (SegBits+1)'(seg_ff) - 1'b1;
                     state_in = ((SegBits+1)'(seg_ff) - 1'b1 < lo_ff) ? ST_T0 : ST_PROBE0;
                  end
               end else begin
                  lo_in = (SegBits+1)'(seg_ff) + 1'b1;
                  state_in = ((SegBits+1)'(seg_ff) + 1'b1 > hi_ff) ? ST_T0 : ST_PROBE0;
               end
            end
         end
         ST_T0: begin
            cmd.rd_addr = table_addr(seg_ff, SelT0);
            mstep_in = 2'd0;
            state_in = ST_INV;
         end
         ST_INV: begin
            cmd.op = OP_CAP_T0;
            cmd.rd_addr = table_addr(seg_ff, SelInv);
            state_in = ST_MUL;
         end
         ST_MUL: begin
            mstep_in = mstep_ff + 2'd1;
            case (mstep_ff)
               2'd0: cmd.op = OP_MUL_T;
               2'd1: cmd.op = OP_MUL_T2;
               2'd2: cmd.op = OP_MUL_T3;
               default: begin
                  cmd.op = OP_WEIGHTS;
                  axis_in = '0; term_in = '0;
                  cmd.rd_addr = table_addr(seg_ff, SelP0);
                  state_in = ST_AXIS;
               end
            endcase
         end
         ST_AXIS: begin
            // word for (axis, term) is on the read port; prefetch the next
            cmd.op = OP_AXIS;
            cmd.axis = axis_ff;
            cmd.term = term_ff;
            cmd.last_term = (term_ff == 2'd3);
            if (term_ff == 2'd3) begin
               term_in = '0;
               axis_in = axis_ff + 2'd1;
               cmd.rd_addr = table_addr(seg_ff, SelP0 + 4'(axis_ff) + 4'd1);
               if (axis_ff == 2'd2) state_in = ST_DONE;
            end else begin
               term_in = term_ff + 2'd1;
               case (term_ff)
                  2'd0:    cmd.rd_addr = table_addr(seg_ff, SelM0 + 4'(axis_ff));
                  2'd1:    cmd.rd_addr = table_addr(seg_ff, SelP1 + 4'(axis_ff));
                  default: cmd.rd_addr = table_addr(seg_ff, SelM1 + 4'(axis_ff));
               endcase
            end
            if (term_sel == SelLimit) state_in = ST_IDLE;
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_ff <= lo_in; hi_ff <= hi_in; seg_ff <= seg_in; last_ff <= last_in;
      axis_ff <= axis_in; term_ff <= term_in; mstep_ff <= mstep_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign seg_out = 6'(seg_ff);
endmodule

>>> hw/rtl/hermite_spline_evaluator.sv
// top level: cubic hermite spline evaluator
// a table write is done in the cycle it is accepted; an accepted evaluate runs range checks
// on the first and last segment bounds, up to seven search probes (address, two compares, decide),
// then two table reads, four multiply/weight steps, twelve accumulate steps and one to finish
// one request in flight; result held until taken, next request accepted the cycle after
// synchronous reset sets num_segments to 1 and idles the sequencer; table is not cleared
module hermite_spline_evaluator (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [6:0]  csr_write_data,
   hse_stream_if.sink   req,
   hse_stream_if.source rsp
);
   import hse_pkg::*;

   logic [6:0] num_segments_ff;
   always_ff @(posedge clock) begin
      if (reset) num_segments_ff <= 7'd1;
      else if (csr_write_enable) num_segments_ff <= csr_write_data;
   end

   req_payload_type req_p;
   dp_cmd_type      cmd;
   dp_status_type   status;
   logic [31:0]     result [9];
   logic            req_ready, req_fire, rsp_valid;
   logic [5:0]      seg_out;

   assign req_p = req.payload;
   assign req.ready = req_ready;
   assign req_fire = req.valid && req_ready;

   hse_controller u_ctrl (
      .clock(clock), .reset(reset),
      .csr_num_segments(num_segments_ff),
      .req_fire(req_fire), .req_is_eval(req_p.req_type),
      .req_ready(req_ready),
      .rsp_ready(rsp.ready), .rsp_valid(rsp_valid),
      .seg_out(seg_out), .cmd(cmd), .status(status)
   );

   hse_datapath u_dp (
      .clock(clock), .cmd(cmd), .req(req_p), .status(status), .result(result)
   );

   assign rsp.valid = rsp_valid;
   always_comb begin
      rsp.payload.segment_used = seg_out;
      rsp.payload.pos_x  = result[0];
      rsp.payload.pos_y  = result[1];
      rsp.payload.pos_z  = result[2];
      rsp.payload.tan_x  = result[3];
      rsp.payload.tan_y  = result[4];
      rsp.payload.tan_z  = result[5];
      rsp.payload.curv_x = result[6];
      rsp.payload.curv_y = result[7];
      rsp.payload.curv_z = result[8];
   end
endmodule
